### rtl/dpst_pkg.sv
// Shared constants, types and helpers for the phase-shifted PWM time base.
`default_nettype none

package dpst_pkg;

    localparam int COUNT_WIDTH = 16;                 // leg counter / period width
    localparam int PROD_WIDTH  = 2 * COUNT_WIDTH;    // ramp phase product width
    localparam int TICK_WIDTH  = COUNT_WIDTH + 1;    // divider tick counter width
    localparam int DIV_STEPS   = PROD_WIDTH;         // one quotient bit per cycle
    localparam int DIV_CNT_WIDTH = $clog2(DIV_STEPS + 1);

    localparam int CFG_INDEX_WIDTH = 8;
    localparam int CFG_DATA_WIDTH  = 16;

    // register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SAMPLE_DIVIDER      = 8'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_RAMP_STEPS          = 8'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_RAMP_ENABLE         = 8'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_INITIAL_HALF_PERIOD = 8'd3;

    // reset values of the registers
    localparam logic [15:0] SAMPLE_DIVIDER_RST      = 16'd1000;
    localparam logic [15:0] RAMP_STEPS_RST          = 16'd5000;
    localparam logic        RAMP_ENABLE_RST         = 1'b1;
    localparam logic [15:0] INITIAL_HALF_PERIOD_RST = 16'd277;

    typedef struct packed {
        logic step_live;   // commit one tick using the port input
        logic div_start;   // latch tick, start ramp phase division
        logic step_held;   // commit latched tick with division result
    } dpst_cmd_t;

    typedef struct packed {
        logic strobe_ramp; // current tick is a strobe with ramp running
        logic div_done;    // quotient ready
    } dpst_status_t;

    // zero period or divisor counts as one
    function automatic logic [COUNT_WIDTH-1:0] at_least_one(input logic [COUNT_WIDTH-1:0] v);
        at_least_one = (v == '0) ? COUNT_WIDTH'(1) : v;
    endfunction

endpackage

`default_nettype wire

### rtl/dpst_div.sv
// Serial restoring divider, one quotient bit per cycle.
`default_nettype none

module dpst_div (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [dpst_pkg::PROD_WIDTH-1:0]  dividend,
    input  wire logic [dpst_pkg::COUNT_WIDTH-1:0] divisor,
    output logic                                done,
    output logic [dpst_pkg::PROD_WIDTH-1:0]       quotient
);
    import dpst_pkg::*;

    logic [COUNT_WIDTH-1:0]   rem_reg, rem_next;
    logic [PROD_WIDTH-1:0]    quo_reg, quo_next;
    logic [COUNT_WIDTH-1:0]   dsr_reg, dsr_next;
    logic [DIV_CNT_WIDTH-1:0] cnt_reg, cnt_next;
    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic [COUNT_WIDTH:0]     rem_sh;
    logic                     fits;

    // shift next dividend bit into the partial remainder
    assign rem_sh = {rem_reg, quo_reg[PROD_WIDTH-1]};
    assign fits   = rem_sh >= {1'b0, dsr_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? COUNT_WIDTH'(rem_sh - {1'b0, dsr_reg}) : rem_sh[COUNT_WIDTH-1:0];
            quo_next = {quo_reg[PROD_WIDTH-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_WIDTH'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

### rtl/dpst_datapath.sv
// Time base state: divider, ramp, phase/period handling, leg counters, config registers.
`default_nettype none

module dpst_datapath (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire dpst_pkg::dpst_cmd_t                cmd,
    output dpst_pkg::dpst_status_t                  status,
    input  wire logic [15:0]                        requested_half_period,
    input  wire logic                               cfg_we,
    input  wire logic [dpst_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [dpst_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
    output logic [15:0]                             leg1_count,
    output logic [15:0]                             leg2_count,
    output logic [15:0]                             half_period,
    output logic [15:0]                             phase_offset,
    output logic                                    sample_strobe,
    output logic                                    ramp_active,
    output logic                                    leg1_falling,
    output logic                                    leg2_falling
);
    import dpst_pkg::*;

    // config registers
    logic [15:0] sample_divider_reg, sample_divider_next;
    logic [COUNT_WIDTH-1:0] ramp_steps_reg, ramp_steps_next;
    logic ramp_enable_reg, ramp_enable_next;

    // time base state
    logic [TICK_WIDTH-1:0]  tick_cnt_reg, tick_cnt_next;
    logic [COUNT_WIDTH-1:0] ramp_cnt_reg, ramp_cnt_next;
    logic [COUNT_WIDTH-1:0] phase_tgt_reg, phase_tgt_next;
    logic [COUNT_WIDTH-1:0] phase_app_reg, phase_app_next;
    logic [COUNT_WIDTH-1:0] active_half_reg, active_half_next;
    logic [COUNT_WIDTH-1:0] pending_reg, pending_next;
    logic [COUNT_WIDTH-1:0] applied_req_reg, applied_req_next;
    logic [COUNT_WIDTH-1:0] leg1_reg, leg1_next;
    logic [COUNT_WIDTH-1:0] leg2_reg, leg2_next;
    logic leg1_dir_reg, leg1_dir_next;
    logic leg2_dir_reg, leg2_dir_next;
    logic strobe_out_reg, strobe_out_next;
    logic [COUNT_WIDTH-1:0] req_hold_reg, req_hold_next;

    logic [TICK_WIDTH-1:0]  tick_inc;
    logic                   strobe;
    logic [COUNT_WIDTH-1:0] ramp_dec;
    logic [COUNT_WIDTH-1:0] req_sel;
    logic [PROD_WIDTH-1:0]  product;
    logic [PROD_WIDTH-1:0]  quotient;
    logic [COUNT_WIDTH-1:0] quot_sat;
    logic                   div_done;
    logic                   step;
    logic                   l1_f, l2_f;
    logic [COUNT_WIDTH-1:0] leg2_pre;

    function automatic logic dir_of(input logic [COUNT_WIDTH-1:0] cnt, input logic falling,
                                    input logic [COUNT_WIDTH-1:0] half);
        if (cnt >= half)
            dir_of = 1'b1;
        else if (cnt == '0)
            dir_of = 1'b0;
        else
            dir_of = falling;
    endfunction

    function automatic logic [COUNT_WIDTH-1:0] cnt_of(input logic [COUNT_WIDTH-1:0] cnt,
                                                      input logic falling);
        if (falling)
            cnt_of = (cnt != '0) ? cnt - 1'b1 : cnt;
        else
            cnt_of = cnt + 1'b1;
    endfunction

    assign tick_inc = tick_cnt_reg + 1'b1;
    assign strobe   = tick_inc > {1'b0, sample_divider_reg};
    assign ramp_dec = ramp_cnt_reg - 1'b1;
    assign req_sel  = cmd.step_held ? req_hold_reg : at_least_one(requested_half_period);
    assign product  = ramp_dec * active_half_reg;
    assign quot_sat = (quotient[PROD_WIDTH-1:COUNT_WIDTH] != '0) ? '1 : quotient[COUNT_WIDTH-1:0];
    assign step     = cmd.step_live || cmd.step_held;

    assign status.strobe_ramp = strobe && (ramp_cnt_reg != '0);
    assign status.div_done    = div_done;

    dpst_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (product),
        .divisor  (at_least_one(ramp_steps_reg)),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb
    begin
        sample_divider_next = sample_divider_reg;
        ramp_steps_next     = ramp_steps_reg;
        ramp_enable_next    = ramp_enable_reg;
        tick_cnt_next       = tick_cnt_reg;
        ramp_cnt_next       = ramp_cnt_reg;
        phase_tgt_next      = phase_tgt_reg;
        phase_app_next      = phase_app_reg;
        active_half_next    = active_half_reg;
        pending_next        = pending_reg;
        applied_req_next    = applied_req_reg;
        leg1_next           = leg1_reg;
        leg2_next           = leg2_reg;
        leg1_dir_next       = leg1_dir_reg;
        leg2_dir_next       = leg2_dir_reg;
        strobe_out_next     = strobe_out_reg;
        req_hold_next       = req_hold_reg;
        l1_f                = leg1_dir_reg;
        l2_f                = leg2_dir_reg;
        leg2_pre            = leg2_reg;

        if (cmd.div_start)
            req_hold_next = req_sel;

        if (step)
        begin
            tick_cnt_next   = strobe ? '0 : tick_inc;
            strobe_out_next = strobe;
            if (strobe)
            begin
                if (ramp_cnt_reg != '0)
                begin
                    ramp_cnt_next  = ramp_dec;
                    phase_tgt_next = quot_sat;
                end
                else
                    pending_next = req_sel;
            end

            leg2_pre = leg2_reg;
            if (phase_app_reg != phase_tgt_next && leg1_reg == phase_tgt_next)
            begin
                phase_app_next = phase_tgt_next;
                leg2_pre       = '0;
            end

            if (pending_next != applied_req_reg && leg1_reg == '0 && leg1_dir_reg
                && ramp_cnt_next == '0)
            begin
                applied_req_next = pending_next;
                active_half_next = at_least_one(pending_next);
            end

            l1_f          = dir_of(leg1_reg, leg1_dir_reg, active_half_next);
            l2_f          = dir_of(leg2_pre, leg2_dir_reg, active_half_next);
            leg1_dir_next = l1_f;
            leg2_dir_next = l2_f;
            leg1_next     = cnt_of(leg1_reg, l1_f);
            leg2_next     = cnt_of(leg2_pre, l2_f);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SAMPLE_DIVIDER:
                begin
                    sample_divider_next = cfg_data;
                end
                REG_RAMP_STEPS:
                begin
                    ramp_steps_next = cfg_data;
                    ramp_cnt_next   = ramp_enable_reg ? cfg_data : '0;
                end
                REG_RAMP_ENABLE:
                begin
                    ramp_enable_next = cfg_data[0];
                    ramp_cnt_next    = cfg_data[0] ? ramp_steps_reg : '0;
                end
                REG_INITIAL_HALF_PERIOD:
                begin
                    active_half_next = at_least_one(cfg_data);
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_divider_reg <= SAMPLE_DIVIDER_RST;
            ramp_steps_reg     <= RAMP_STEPS_RST;
            ramp_enable_reg    <= RAMP_ENABLE_RST;
            tick_cnt_reg       <= '0;
            ramp_cnt_reg       <= RAMP_ENABLE_RST ? RAMP_STEPS_RST : '0;
            phase_tgt_reg      <= '0;
            phase_app_reg      <= '0;
            active_half_reg    <= INITIAL_HALF_PERIOD_RST;
            pending_reg        <= '0;
            applied_req_reg    <= '0;
            leg1_reg           <= '0;
            leg2_reg           <= '0;
            leg1_dir_reg       <= 1'b1;
            leg2_dir_reg       <= 1'b1;
            strobe_out_reg     <= 1'b0;
        end
        else
        begin
            sample_divider_reg <= sample_divider_next;
            ramp_steps_reg     <= ramp_steps_next;
            ramp_enable_reg    <= ramp_enable_next;
            tick_cnt_reg       <= tick_cnt_next;
            ramp_cnt_reg       <= ramp_cnt_next;
            phase_tgt_reg      <= phase_tgt_next;
            phase_app_reg      <= phase_app_next;
            active_half_reg    <= active_half_next;
            pending_reg        <= pending_next;
            applied_req_reg    <= applied_req_next;
            leg1_reg           <= leg1_next;
            leg2_reg           <= leg2_next;
            leg1_dir_reg       <= leg1_dir_next;
            leg2_dir_reg       <= leg2_dir_next;
            strobe_out_reg     <= strobe_out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_hold_reg <= req_hold_next;
    end

    assign leg1_count    = leg1_reg;
    assign leg2_count    = leg2_reg;
    assign half_period   = active_half_reg;
    assign phase_offset  = phase_tgt_reg;
    assign sample_strobe = strobe_out_reg;
    assign ramp_active   = (ramp_cnt_reg != '0);
    assign leg1_falling  = leg1_dir_reg;
    assign leg2_falling  = leg2_dir_reg;

endmodule

`default_nettype wire

### rtl/dpst_ctrl.sv
// Controller: input/output handshake and sequencing of ramp strobe ticks.
`default_nettype none

module dpst_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    input  wire dpst_pkg::dpst_status_t status,
    output dpst_pkg::dpst_cmd_t         cmd
);
    import dpst_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;  // one tick per cycle unless the output is stalled
    localparam logic [1:0] ST_DIV  = 2'd1;  // phase division running
    localparam logic [1:0] ST_FIN  = 2'd2;  // commit held tick

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;
    logic       accept;

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != ST_IDLE) || !out_free;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (status.strobe_ramp)
                    begin
                        cmd.div_start = 1'b1;
                        state_next    = ST_DIV;
                    end
                    else
                        cmd.step_live = 1'b1;
                end
            end
            ST_DIV:
            begin
                if (status.div_done)
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    cmd.step_held = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.step_live || cmd.step_held)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

### rtl/dual_updown_pwm_phase_shift_timebase_unit.sv
// Top level of the phase-shifted dual up/down PWM time base.
`default_nettype none

// Each input beat is one time-base tick carrying the requested half period;
// each tick returns one output beat with both triangle leg counters, their
// directions, the half period and phase target in effect, the sample strobe
// and the soft-start flag. An ordinary tick is accepted whenever the output
// register is empty or being taken in the same cycle, so ticks stream at one
// per clock. A tick on which the sample strobe fires while the soft-start
// ramp is running holds the input off: the accept cycle loads the serial
// divider with the 16x16 product (ramp-1)*half_period, the divider produces
// the 32-bit quotient one bit per cycle, its registered done flag moves the
// controller to the commit state, and that state commits the tick with the
// new phase target (waiting while the output register is stalled). in_stall
// stays high during that time. The configuration port is always ready
// (cfg_ready tied high); write it only when no beat is in flight. Writing
// ramp_steps or ramp_enable restarts the ramp if it is enabled and stops it
// otherwise, writing initial_half_period loads the peak in effect, other
// indexes are dropped. Leg counters are 16 bits wide; a half period or ramp
// step count of zero is treated as one.

module dual_updown_pwm_phase_shift_timebase_unit (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // tick input
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic [15:0]                          requested_half_period,
    // result output
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic [15:0]                               leg1_count,
    output logic [15:0]                               leg2_count,
    output logic [15:0]                               half_period,
    output logic [15:0]                               phase_offset,
    output logic                                      sample_strobe,
    output logic                                      ramp_active,
    output logic                                      leg1_falling,
    output logic                                      leg2_falling,
    // configuration write
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [dpst_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [dpst_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);
    import dpst_pkg::*;

    dpst_cmd_t    cmd;
    dpst_status_t status;

    assign cfg_ready = 1'b1;

    // sequencing: handshakes, divider launch and commit
    dpst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // all time-base state; outputs come straight from its registers
    dpst_datapath u_datapath (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .cmd                   (cmd),
        .status                (status),
        .requested_half_period (requested_half_period),
        .cfg_we                (cfg_valid && cfg_ready),
        .cfg_index             (cfg_index),
        .cfg_data              (cfg_data),
        .leg1_count            (leg1_count),
        .leg2_count            (leg2_count),
        .half_period           (half_period),
        .phase_offset          (phase_offset),
        .sample_strobe         (sample_strobe),
        .ramp_active           (ramp_active),
        .leg1_falling          (leg1_falling),
        .leg2_falling          (leg2_falling)
    );

    // a tick never commits over a result that is still waiting
    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step_live || cmd.step_held) |-> !(out_valid && out_stall))
        else $error("tick committed over a held output beat");

    // a committed tick shows up as an output beat next cycle
    a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step_live || cmd.step_held) |=> out_valid)
        else $error("committed tick produced no output beat");

    // once a division starts, input is held off
    a_div_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> in_stall)
        else $error("input accepted during phase division");

    // divider finishes only while a ramp tick is in flight
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        status.div_done |-> in_stall)
        else $error("divider finished with no ramp tick pending");

endmodule

`default_nettype wire
